@@ hdl/assert_macros.svh @@
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/drs_pkg.sv @@
package drs_pkg;

  // Field widths
  localparam int TF_W       = 16;
  localparam int LEN_W      = 24;
  localparam int CF_W       = 40;
  localparam int NDOC_W     = 40;
  localparam int MEAN_W     = 32;
  localparam int SCORE_W    = 32;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLL_DOCS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_LEN  = 1'd1;

  localparam logic [NDOC_W-1:0] NDOC_RST = 40'd1;
  localparam logic [MEAN_W-1:0] MEAN_RST = 32'd256;

  localparam int SCORE_FRAC_BITS_DEF = 16;

  // Log2 in Q32: 6 integer bits, 32 fraction bits
  localparam int LG_FRAC = 32;
  localparam int LG_W    = 38;
  localparam int LOG_LAT = 33;
  localparam int DIV_LAT = 32;
  localparam int MEAN_FRAC = 8;

  // Signed log sums and the bracketed term
  localparam int L_W = 42;
  localparam int T_W = 64;
  localparam logic signed [L_W-1:0] LOG2_TWO_PI_Q32 = 42'sd11388089162;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;
  localparam logic [SCORE_W-1:0] SCORE_MIN = 32'h8000_0000;

  // Per-posting flags carried down the pipe
  typedef struct packed {
    logic invalid;  // no defined score
    logic neg_inf;  // N or mean is zero
  } drs_flags_t;

endpackage

@@ hdl/drs_chan_if.sv @@
// Posting request channel
interface drs_in_if;
  logic                         valid;
  logic                         ready;
  logic [drs_pkg::TF_W-1:0]     term_freq;
  logic [drs_pkg::LEN_W-1:0]    doc_length;
  logic [drs_pkg::CF_W-1:0]     coll_freq;

  modport source (output valid, output term_freq, output doc_length, output coll_freq,
                  input ready);
  modport sink   (input valid, input term_freq, input doc_length, input coll_freq,
                  output ready);
endinterface

// Score result channel
interface drs_out_if;
  logic                         valid;
  logic                         ready;
  logic [drs_pkg::SCORE_W-1:0]  score;
  logic                         invalid;

  modport source (output valid, output score, output invalid, input ready);
  modport sink   (input valid, input score, input invalid, output ready);
endinterface

@@ hdl/dph_relevance_score.sv @@
// DPH relevance score, one posting per request.
// Throughput: one request per cycle; the 32-stage log2 squaring chains and the
// two chained 32-stage dividers set the depth. The whole pipe holds while a result waits.
// Reset: clears all valid bits, N to 1 and mean length to 1.0.
`include "assert_macros.svh"
module dph_relevance_score #(
  parameter int SCORE_FRAC_BITS = drs_pkg::SCORE_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  drs_in_if.sink                           in_chan,
  drs_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [drs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SHIFT  = 65 - SCORE_FRAC_BITS;
  localparam int FULL_W = 97;
  localparam int RES_W  = FULL_W - SHIFT;
  localparam int L_W    = drs_pkg::L_W;
  localparam int T_W    = drs_pkg::T_W;

  // Stage numbers after the input register
  localparam int ST_LOG = drs_pkg::LOG_LAT;
  localparam int ST_Q   = drs_pkg::DIV_LAT + 1;
  localparam int ST_N   = ST_Q + drs_pkg::DIV_LAT;
  localparam int ST_T   = ST_LOG + 3;
  localparam int ST_SUM = ST_N + 2;
  localparam int ST_OUT = ST_N + 3;

  logic en;
  logic [ST_OUT:0] v_r;

  logic [drs_pkg::NDOC_W-1:0] ndoc_cfg_r;
  logic [drs_pkg::MEAN_W-1:0] mean_cfg_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndoc_cfg_r <= drs_pkg::NDOC_RST;
      mean_cfg_r <= drs_pkg::MEAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drs_pkg::REG_COLL_DOCS: ndoc_cfg_r <= cfg_data;
        drs_pkg::REG_MEAN_LEN:  mean_cfg_r <= cfg_data[drs_pkg::MEAN_W-1:0];
      endcase
    end
  end

  // Global advance: move when the output slot is free or being drained
  assign en           = !v_r[ST_OUT] || out_chan.ready;
  assign in_chan.ready = en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ST_OUT-1:0], in_chan.valid};
    end
  end

  // Stage 0: input register
  logic [drs_pkg::TF_W-1:0]   tf_r;
  logic [drs_pkg::LEN_W-1:0]  len_r;
  logic [drs_pkg::CF_W-1:0]   cf_r;
  logic [drs_pkg::NDOC_W-1:0] ndoc_r;
  logic [drs_pkg::MEAN_W-1:0] mean_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tf_r   <= in_chan.term_freq;
      len_r  <= in_chan.doc_length;
      cf_r   <= in_chan.coll_freq;
      ndoc_r <= ndoc_cfg_r;
      mean_r <= mean_cfg_r;
    end
  end

  drs_pkg::drs_flags_t flags0, flags_d;
  logic [drs_pkg::LEN_W-1:0] rest;

  assign rest = len_r - drs_pkg::LEN_W'(tf_r);
  assign flags0.invalid = (tf_r == '0) || (drs_pkg::LEN_W'(tf_r) >= len_r) || (cf_r == '0);
  assign flags0.neg_inf = (ndoc_r == '0) || (mean_r == '0);

  drs_delay #(.WIDTH($bits(drs_pkg::drs_flags_t)), .DEPTH(ST_SUM)) u_flags_dly (
    .clk(clk), .en(en), .d(flags0), .q(flags_d)
  );

  // Log units
  logic [drs_pkg::LG_W-1:0] lg_tf, lg_mean, lg_ndoc, lg_len, lg_cf, lg_rest;

  drs_log2 #(.XW(drs_pkg::TF_W))   u_lg_tf   (.clk(clk), .en(en), .x(tf_r),   .lg(lg_tf));
  drs_log2 #(.XW(drs_pkg::MEAN_W)) u_lg_mean (.clk(clk), .en(en), .x(mean_r), .lg(lg_mean));
  drs_log2 #(.XW(drs_pkg::NDOC_W)) u_lg_ndoc (.clk(clk), .en(en), .x(ndoc_r), .lg(lg_ndoc));
  drs_log2 #(.XW(drs_pkg::LEN_W))  u_lg_len  (.clk(clk), .en(en), .x(len_r),  .lg(lg_len));
  drs_log2 #(.XW(drs_pkg::CF_W))   u_lg_cf   (.clk(clk), .en(en), .x(cf_r),   .lg(lg_cf));
  drs_log2 #(.XW(drs_pkg::LEN_W))  u_lg_rest (.clk(clk), .en(en), .x(rest),   .lg(lg_rest));

  // 1-f = rest/len in Q32
  logic [31:0] g;
  drs_div #(.DW(drs_pkg::LEN_W)) u_div_g (
    .clk(clk), .en(en), .rem0(rest), .low('0), .den(len_r), .quo(g)
  );

  // (1-f)^2
  logic [63:0] g_sq;
  logic [31:0] q_r;
  assign g_sq = 64'(g) * 64'(g);
  always_ff @(posedge clk) begin
    if (en) q_r <= g_sq[63:32];
  end

  // tf aligned with the log results and q
  logic [drs_pkg::TF_W-1:0] tf_d;
  drs_delay #(.WIDTH(drs_pkg::TF_W), .DEPTH(ST_Q)) u_tf_dly (
    .clk(clk), .en(en), .d(tf_r), .q(tf_d)
  );

  // norm = q / (tf+1)
  logic [31:0] n_q;
  drs_div #(.DW(drs_pkg::TF_W + 1)) u_div_n (
    .clk(clk), .en(en), .rem0('0), .low(q_r),
    .den(drs_pkg::TF_W'(1) + (drs_pkg::TF_W + 1)'(tf_d)), .quo(n_q)
  );

  // Log sums
  logic signed [L_W-1:0] s_tf, s_mean, s_ndoc, s_len, s_cf, s_rest;
  logic signed [L_W-1:0] l1_r, l2_r, l2_p_r;
  logic [drs_pkg::TF_W-1:0] tf_l_r;

  assign s_tf   = $signed(L_W'(lg_tf));
  assign s_mean = $signed(L_W'(lg_mean));
  assign s_ndoc = $signed(L_W'(lg_ndoc));
  assign s_len  = $signed(L_W'(lg_len));
  assign s_cf   = $signed(L_W'(lg_cf));
  assign s_rest = $signed(L_W'(lg_rest));

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r   <= s_tf + s_mean - (L_W'(drs_pkg::MEAN_FRAC) <<< drs_pkg::LG_FRAC)
                + s_ndoc - s_len - s_cf;
      l2_r   <= drs_pkg::LOG2_TWO_PI_Q32 + s_tf + s_rest - s_len;
      tf_l_r <= tf_d;
    end
  end

  // 2*tf*L1
  logic signed [T_W-1:0] p_r;
  logic signed [T_W-1:0] tf2;
  assign tf2 = $signed(T_W'({tf_l_r, 1'b0}));
  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= T_W'(l1_r) * tf2;
      l2_p_r <= l2_r;
    end
  end

  // T and its magnitude
  logic signed [T_W-1:0] t_sum;
  logic [T_W-1:0] mag_r;
  logic neg_r;
  assign t_sum = p_r + T_W'(l2_p_r);
  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= t_sum[T_W-1];
      mag_r <= t_sum[T_W-1] ? T_W'(-t_sum) : T_W'(t_sum);
    end
  end

  logic [T_W:0] nm_d;
  drs_delay #(.WIDTH(T_W + 1), .DEPTH(ST_N - ST_T)) u_mag_dly (
    .clk(clk), .en(en), .d({neg_r, mag_r}), .q(nm_d)
  );

  // Partial products of |T| * norm
  logic [63:0] pplo_r, pphi_r;
  logic neg_pp_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pplo_r   <= 64'(nm_d[31:0]) * 64'(n_q);
      pphi_r   <= 64'(nm_d[63:32]) * 64'(n_q);
      neg_pp_r <= nm_d[T_W];
    end
  end

  // Combine and add rounding half
  logic [FULL_W-1:0] full_r;
  logic neg_s_r;
  always_ff @(posedge clk) begin
    if (en) begin
      full_r  <= (FULL_W'(pphi_r) << 32) + FULL_W'(pplo_r) + (FULL_W'(1) << (SHIFT - 1));
      neg_s_r <= neg_pp_r;
    end
  end

  // Scale, sign and saturate into the output register
  logic [RES_W-1:0] res, res_neg;
  logic [drs_pkg::SCORE_W-1:0] score_nxt;
  logic over;
  logic [drs_pkg::SCORE_W-1:0] score_r;
  logic invalid_r;

  assign res     = full_r[FULL_W-1:SHIFT];
  assign res_neg = RES_W'(0) - res;
  assign over    = (res >> 31) != '0;

  always_comb begin
    priority if (flags_d.invalid) begin
      score_nxt = '0;
    end else if (flags_d.neg_inf) begin
      score_nxt = drs_pkg::SCORE_MIN;
    end else if (neg_s_r) begin
      score_nxt = over ? drs_pkg::SCORE_MIN : res_neg[drs_pkg::SCORE_W-1:0];
    end else begin
      score_nxt = over ? drs_pkg::SCORE_MAX : res[drs_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      score_r   <= score_nxt;
      invalid_r <= flags_d.invalid;
    end
  end

  assign out_chan.valid   = v_r[ST_OUT];
  assign out_chan.score   = score_r;
  assign out_chan.invalid = invalid_r;

  // Checks
  `ASSERT_ALWAYS(a_invalid_zero, clk, rst_n, !(out_chan.valid && out_chan.invalid) || (out_chan.score == '0))
  `ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, $stable(v_r))
  `ASSERT_NEXT(a_bubble_moves, clk, rst_n, en && !v_r[ST_OUT-1], !v_r[ST_OUT])

endmodule

@@ hdl/drs_delay.sv @@
// Enabled shift line
module drs_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

@@ hdl/drs_log2.sv @@
// Pipelined log2 in Q32: normalize stage, then one squaring per fraction bit
module drs_log2 #(
  parameter int XW = 40
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [XW-1:0]            x,
  output logic [drs_pkg::LG_W-1:0] lg
);

  localparam int NW = (XW < 32) ? 32 : XW;
  localparam int EW = $clog2(NW);
  localparam int NF = drs_pkg::LG_FRAC;

  logic [NW-1:0] xn;
  logic [EW-1:0] pos;
  logic [NW-1:0] sh;

  logic [EW-1:0] e_r [0:NF];
  logic [31:0]   m_r [0:NF];
  logic [NF-1:0] f_r [0:NF];

  // Top set bit and alignment onto bit 31
  always_comb begin
    xn  = NW'(x);
    pos = '0;
    for (int i = 0; i < NW; i++) begin
      if (xn[i]) pos = EW'(i);
    end
    sh = xn << (EW'(NW - 1) - pos);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= pos;
      m_r[0] <= sh[NW-1 -: 32];
      f_r[0] <= '0;
    end
  end

  // Squaring stages, MSB of the fraction first
  for (genvar i = 1; i <= NF; i++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(m_r[i-1]) * 64'(m_r[i-1]);
    assign t  = sq[63:31];

    always_ff @(posedge clk) begin
      if (en) begin
        e_r[i] <= e_r[i-1];
        if (t[32]) begin
          m_r[i] <= t[32:1];
          f_r[i] <= f_r[i-1] | (NF'(1) << (NF - i));
        end else begin
          m_r[i] <= t[31:0];
          f_r[i] <= f_r[i-1];
        end
      end
    end
  end

  assign lg = drs_pkg::LG_W'({e_r[NF], f_r[NF]});

endmodule

@@ hdl/drs_div.sv @@
// Pipelined restoring divider: 32 quotient bits, one per stage.
// Dividend is rem0:low with rem0 < den.
module drs_div #(
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem0,
  input  logic [31:0]   low,
  input  logic [DW-1:0] den,
  output logic [31:0]   quo
);

  logic [DW-1:0] rem_r [0:32];
  logic [31:0]   low_r [0:32];
  logic [DW-1:0] den_r [0:32];
  logic [31:0]   quo_r [0:32];

  assign rem_r[0] = rem0;
  assign low_r[0] = low;
  assign den_r[0] = den;
  assign quo_r[0] = '0;

  for (genvar i = 0; i < 32; i++) begin : g_step
    logic [DW:0] r2;
    logic [DW:0] diff;
    assign r2   = {rem_r[i], low_r[i][31]};
    assign diff = r2 - {1'b0, den_r[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        low_r[i+1] <= {low_r[i][30:0], 1'b0};
        den_r[i+1] <= den_r[i];
        if (!diff[DW]) begin
          rem_r[i+1] <= diff[DW-1:0];
          quo_r[i+1] <= {quo_r[i][30:0], 1'b1};
        end else begin
          rem_r[i+1] <= r2[DW-1:0];
          quo_r[i+1] <= {quo_r[i][30:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_r[32];

endmodule
